// ===== rtl/swa_pkg.sv =====
// shared constants and types for the sliding window average block
package swa_pkg;

    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 12;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_DONE
    } swa_state_t;

endpackage

// ===== rtl/swa_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module swa_div
    import swa_pkg::*;
#(
    parameter int SUM_BITS = 16,
    parameter int CNT_BITS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SUM_BITS-1:0] dividend,
    input  logic [CNT_BITS-1:0] divisor,
    output logic                done,
    output logic [SUM_BITS-1:0] quotient
);

    localparam int ITER_BITS = $clog2(SUM_BITS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [ITER_BITS-1:0] iter_reg;
    logic [CNT_BITS-1:0]  rem_reg;
    logic [CNT_BITS-1:0]  rem_next;
    logic [SUM_BITS-1:0]  quo_reg;
    logic [CNT_BITS-1:0]  dvs_reg;
    logic [CNT_BITS:0]    trial;
    logic                 qbit;

    // shift the next dividend bit into the partial remainder and try a subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[SUM_BITS-1]};
        qbit     = (trial >= {1'b0, dvs_reg});
        rem_next = qbit ? CNT_BITS'(trial - {1'b0, dvs_reg}) : CNT_BITS'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            // done pulses for one cycle after the last quotient bit
            done_reg <= !start && busy_reg && (iter_reg == ITER_BITS'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_BITS'(SUM_BITS);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - ITER_BITS'(1);
                if (iter_reg == ITER_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SUM_BITS-2:0], qbit};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/sliding_window_average.sv =====
// sliding window average: ring store of recent samples, running sum and divider
//
// Usage: samples enter on the s_ stream (s_tdata carries one unsigned sample),
// averages leave on the m_ stream (m_tdata carries one unsigned average).
// Each sample yields exactly one average: the sum of the samples held divided
// by how many are held (up to WINDOW), truncated. While the window fills this
// is the mean of everything seen since reset.
// Each sample goes through these steps, with s_tready low throughout: the
// oldest entry of the ring store is read at the request edge, then the running
// sum and store are updated, the bit-serial divider works out the quotient,
// its done flag is registered, and the output register is loaded. No new
// sample is taken until the average of the current one has been loaded into
// the output register.
// The result sits in an output register; the next sample is taken while it
// waits. If the receiver stalls, a finished average waits in the divider until
// the output register frees up, and no further sample is taken meanwhile.
// Reset empties the window: fill count, running sum and write position clear.
module sliding_window_average
    import swa_pkg::*;
#(
    parameter int WINDOW      = WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_tdata,   // sample
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((SAMPLE_BITS + 7) / 8)*8-1:0] m_tdata    // average
);

    localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int CNT_BITS   = $clog2(WINDOW + 1);
    localparam int POS_BITS   = $clog2(WINDOW);

    swa_state_t state_reg, state_next;

    logic [SAMPLE_BITS-1:0] store_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] old_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [POS_BITS-1:0]    pos_reg, pos_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic                   out_valid_reg, out_valid_next;

    logic                   in_accept;
    logic                   rd_en;
    logic                   wr_en;
    logic                   div_start;
    logic                   div_done;
    logic                   out_load;
    logic                   window_full;
    logic [SUM_BITS-1:0]    quotient;

    assign in_accept   = s_tvalid && s_tready;
    assign window_full = (count_reg == CNT_BITS'(WINDOW));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        s_tready       = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                wr_en = 1'b1;
                // drop the oldest sample once the window is full
                if (window_full)
                begin
                    sum_next = sum_reg - SUM_BITS'(old_reg) + SUM_BITS'(sample_reg);
                end
                else
                begin
                    sum_next   = sum_reg + SUM_BITS'(sample_reg);
                    count_next = count_reg + CNT_BITS'(1);
                end
                if (pos_reg == POS_BITS'(WINDOW - 1))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next = pos_reg + POS_BITS'(1);
                end
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ring store: oldest entry read on request, new sample written in the next cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[pos_reg] <= sample_reg;
        end
        if (rd_en)
        begin
            old_reg <= store_mem[pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (out_load)
        begin
            avg_reg <= quotient[SAMPLE_BITS-1:0];
        end
    end

    swa_div #(
        .SUM_BITS (SUM_BITS),
        .CNT_BITS (CNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (quotient)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_BITS'(avg_reg);

endmodule

// ===== rtl/swa_checker.sv =====
// port-level checks for the sliding window average block, bound to the top level
module swa_checker
    import swa_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_tdata,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((SAMPLE_BITS + 7) / 8)*8-1:0] m_tdata
);

    // one sample at a time: busy right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("swa: input ready right after a request");

    // an average needs the update and divide, so it never appears right after a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##1 !$rose(m_tvalid) ##1 !$rose(m_tvalid))
        else $error("swa: average offered too early");

    // a new average is only loaded while the input side is busy
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("swa: average appeared while idle");

    // stalled average holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("swa: stalled average changed");

endmodule

bind sliding_window_average swa_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/sliding_window_average_tb.sv =====
// self-checking testbench for the sliding window average block
`timescale 1ns / 1ps

module sliding_window_average_tb
    import swa_pkg::*;
;

    localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
    localparam int TDATA_W      = ((SAMPLE_W + 7) / 8) * 8;
    localparam int SUM_W        = $clog2(WINDOW_DEF * (1 << SAMPLE_W));
    localparam int RAND_ITEMS   = 2000;
    localparam int CALM_ITEMS   = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

    typedef struct packed
    {
        logic [TDATA_W-1:0]  word;
        logic                typed;
        logic [SAMPLE_W-1:0] avg;
    } stim_row_t;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [TDATA_W-1:0]  s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [TDATA_W-1:0]  m_tdata;

    // predictor state: window contents, next slot, samples held, sum
    logic [SAMPLE_W-1:0] ring [WINDOW_DEF];
    int                  wr_slot = 0;
    int                  held    = 0;
    logic [SUM_W-1:0]    acc     = '0;

    logic [SAMPLE_W-1:0] avg_due [$];
    stim_row_t           stim_rows [$];
    logic [SAMPLE_W-1:0] avg_want;
    bit                  idle_allowed = 1'b1;
    int                  err_count    = 0;
    int                  hold_left    = 0;
    int                  quiet_cycles = 0;

    sliding_window_average dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < WINDOW_DEF; i++)
            ring[i] = '0;
    end

    function automatic logic [SAMPLE_W-1:0] next_average(input logic [SAMPLE_W-1:0] smp);
        if (held == WINDOW_DEF)
            acc = acc - ring[wr_slot];
        else
            held++;
        ring[wr_slot] = smp;
        acc = acc + smp;
        wr_slot = (wr_slot == WINDOW_DEF - 1) ? 0 : wr_slot + 1;
        return SAMPLE_W'(acc / held);
    endfunction

    // after an optional idle gap, offer one sample request, wait for the handshake, then queue its expected average
    task automatic send_sample(input logic [TDATA_W-1:0] word, input logic typed,
                               input logic [SAMPLE_W-1:0] avg);
        logic [SAMPLE_W-1:0] predicted;
        if (idle_allowed && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = next_average(word[SAMPLE_W-1:0]);
        avg_due.push_back(typed ? avg : predicted);
    endtask

    initial
    begin : stimulus
        int                 mode;
        logic [TDATA_W-1:0] word;

        // full-scale fill after reset, drain to zero, pad bits, alternating bits
        for (int i = 0; i < WINDOW_DEF; i++)
            stim_rows.push_back('{TDATA_W'(FULL_SCALE), 1'b1, FULL_SCALE});
        for (int i = 0; i < WINDOW_DEF - 1; i++)
            stim_rows.push_back('{'0, 1'b0, '0});
        stim_rows.push_back('{'0, 1'b1, '0});
        stim_rows.push_back('{16'hF001, 1'b0, '0});
        stim_rows.push_back('{16'hA555, 1'b0, '0});
        stim_rows.push_back('{16'h0555, 1'b0, '0});
        stim_rows.push_back('{16'h0AAA, 1'b0, '0});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_sample(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].avg);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            // every fourth block of 100 requests, and the last CALM_ITEMS, run without idling or output stalls
            idle_allowed = (i < RAND_ITEMS - CALM_ITEMS) && ((i / 100) % 4 != 3);
            mode = $urandom_range(0, 9);
            word = '0;
            case (mode)
                0:       word[SAMPLE_W-1:0] = '0;
                1:       word[SAMPLE_W-1:0] = FULL_SCALE;
                2:       word[SAMPLE_W-1:0] = SAMPLE_W'($urandom_range(0, 15));
                3:       word[SAMPLE_W-1:0] = SAMPLE_W'($urandom_range(int'(FULL_SCALE) - 15,
                                                                       int'(FULL_SCALE)));
                default: word[SAMPLE_W-1:0] = SAMPLE_W'($urandom_range(0, int'(FULL_SCALE)));
            endcase
            send_sample(word, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (avg_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0 && avg_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (avg_due.size() == 0)
            begin
                $error("average: no request pending, actual %0d", m_tdata[SAMPLE_W-1:0]);
                err_count++;
            end
            else
            begin
                avg_want = avg_due.pop_front();
                if (m_tdata[SAMPLE_W-1:0] !== avg_want)
                begin
                    $error("average mismatch: expected %0d, actual %0d",
                           avg_want, m_tdata[SAMPLE_W-1:0]);
                    err_count++;
                end
            end
        end

        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (idle_allowed && $urandom_range(0, 5) == 0)
        begin
            hold_left = $urandom_range(1, 14) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

// ===== sliding_window_average.f =====
rtl/swa_pkg.sv
rtl/swa_div.sv
rtl/sliding_window_average.sv
rtl/swa_checker.sv
sim/sliding_window_average_tb.sv
